@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spq_pkg: shared types and helpers for the sorted priority queue
// Command codes, status codes, cell control struct, IEEE compare helpers.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_PEEK  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // broadcast control to every cell
   typedef struct packed {
      logic        push;
      logic        pop;
      logic        force_head;
      logic [31:0] value;
   } cell_ctrl_type;

   function automatic logic is_nan(input logic [31:0] b);
      return b[30:0] > 31'h7F800000;
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] b);
      if (b[30:0] == 31'd0) return 32'h8000_0000;
      if (b[31]) return ~b;
      return b | 32'h8000_0000;
   endfunction

   // a > b under IEEE rules
   function automatic logic ieee_gt(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      return order_key(a) > order_key(b);
   endfunction

   // a <= b under IEEE rules
   function automatic logic ieee_le(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      return order_key(a) <= order_key(b);
   endfunction

endpackage
`default_nettype wire

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spq_cell: one storage slot of the sorted chain
// Holds one entry; shifts right on insert, left on pop.
// ---------------------------------------------------------------------------
module spq_cell (
   input  wire logic                  clock,
   input  wire spq_pkg::cell_ctrl_type ctrl,
   input  wire logic                  valid,       // this slot holds an entry
   input  wire logic                  left_ins,    // left neighbor inserts at or left of it
   input  wire logic [31:0]           left_data,
   input  wire logic [31:0]           right_data,
   output      logic                  ins_here_or_left,
   output      logic [31:0]           data
);
   import spq_pkg::*;

   logic [31:0] data_ff, data_in;
   logic        hit;

   // slot takes the value where the first greater entry sits (or free slot, forced head)
   always_comb begin
      hit = ctrl.force_head || !valid || ieee_gt(data_ff, ctrl.value);
      ins_here_or_left = left_ins || hit;
      data_in = data_ff;
      if (ctrl.push) begin
         if (left_ins) data_in = left_data;
         else if (hit) data_in = ctrl.value;
      end else if (ctrl.pop) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule
`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_priority_queue: min priority queue of IEEE single values
// A command transfer yields its response in the cycle after it.
// Throughput: one command per cycle if responses drain; cells update in parallel.
// The response register and a cleared-on-take valid let a new command enter
// while the previous response waits, as long as the response slot drains.
// Reset: synchronous; empties the queue, entry storage is not cleared.
// ---------------------------------------------------------------------------
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // head_value[31:0], is_empty[32], zero pad
   output      logic [1:0]  rsp_tuser    // status[1:0]
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]  count_ff, count_in;
   logic           rsp_valid_ff;
   logic [31:0]    rsp_head;
   logic           rsp_empty;
   logic [1:0]     status_ff;

   logic           xfer;
   logic [1:0]     cmd;
   logic [31:0]    val;
   logic           is_full, is_zero;
   cell_ctrl_type  ctrl;
   logic [1:0]     status_in;

   logic [31:0]    cell_data [CAPACITY];
   logic           cell_ins  [CAPACITY];

   // accept when the response slot is free or being taken this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign xfer = req_tvalid && req_tready;
   assign cmd  = req_tuser;
   assign val  = req_tdata;
   assign is_full = count_ff == CW'(CAPACITY);
   assign is_zero = count_ff == '0;

   always_comb begin
      ctrl.value      = val;
      ctrl.force_head = is_zero || ieee_le(val, cell_data[0]);
      ctrl.push       = xfer && cmd == CMD_PUSH && !is_full;
      ctrl.pop        = xfer && cmd == CMD_POP && !is_zero;
      count_in  = count_ff;
      status_in = STATUS_OK;
      unique case (cmd)
         CMD_PUSH: begin
            if (is_full) status_in = STATUS_FULL;
            else count_in = count_ff + CW'(1);
         end
         CMD_POP: begin
            if (is_zero) status_in = STATUS_EMPTY;
            else count_in = count_ff - CW'(1);
         end
         CMD_CLEAR: count_in = '0;
         default: if (is_zero) status_in = STATUS_EMPTY;
      endcase
   end

   // chain of cells, slot 0 is the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic        lins;
      logic [31:0] ldat, rdat;
      if (i == 0) begin : g_first
         assign lins = 1'b0;
         assign ldat = val;
      end else begin : g_mid
         assign lins = cell_ins[i-1];
         assign ldat = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rdat = cell_data[i];
      end else begin : g_inner
         assign rdat = cell_data[i+1];
      end
      spq_cell u_cell (
         .clock            (clock),
         .ctrl             (ctrl),
         .valid            (CW'(i) < count_ff),
         .left_ins         (lins),
         .left_data        (ldat),
         .right_data       (rdat),
         .ins_here_or_left (cell_ins[i]),
         .data             (cell_data[i])
      );
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (xfer) count_ff <= count_in;
         if (xfer) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // hold the status of the command; head comes from the updated chain
   always_ff @(posedge clock) begin
      if (xfer) status_ff <= status_in;
   end

   always_comb begin
      rsp_empty = count_ff == '0;
      rsp_head  = rsp_empty ? 32'd0 : cell_data[0];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_empty, rsp_head};
   assign rsp_tuser  = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count over capacity");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tuser))
      else $error("response lost while stalled");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      xfer && cmd == CMD_PUSH && is_full |=> count_ff == CW'(CAPACITY))
      else $error("push into full queue changed count");
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted priority queue
// Drives push, pop, clear and peek commands under bursty traffic and random
// back-pressure, keeps a shadow sorted list and checks every response.
// ---------------------------------------------------------------------------
module tb_top;
   import spq_pkg::*;

   localparam int CAP       = 16;
   localparam int CYCLE_MAX = 400000;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] value;
   } cmd_item_type;

   typedef struct packed {
      logic [31:0] head_value;
      logic        is_empty;
      logic [1:0]  status;
   } head_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   sorted_priority_queue #(.CAPACITY(CAP)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   cmd_item_type    pending_cmds[$];
   head_report_type expected_heads[$];
   logic [31:0]     shadow_list[$];
   int              errors = 0;
   int              cycles = 0;
   bit              hold_sender = 1'b0;   // set by the stimulus to pause the sender
   int              long_stall = 0;       // receiver hold-off, cycles to go
   int              gap_left = 0;
   int              burst_left = 0;

   // IEEE compare on raw bits; false with any NaN, -0 equals +0.
   function automatic logic [31:0] sort_key(input logic [31:0] b);
      if (b[30:0] == 31'd0) return 32'h8000_0000;
      return b[31] ? ~b : (b | 32'h8000_0000);
   endfunction

   function automatic bit nan_bits(input logic [31:0] b);
      return b[30:0] > 31'h7F80_0000;
   endfunction

   // Apply one command to the shadow list and return the expected report.
   function automatic head_report_type apply_command(input cmd_item_type c);
      head_report_type r;
      int              pos;
      r.status = STATUS_OK;
      case (c.command)
         CMD_PUSH: begin
            if (shadow_list.size() >= CAP) begin
               r.status = STATUS_FULL;
            end else begin
               if (shadow_list.size() == 0 ||
                   (!nan_bits(c.value) && !nan_bits(shadow_list[0]) &&
                    sort_key(c.value) <= sort_key(shadow_list[0]))) begin
                  pos = 0;
               end else begin
                  pos = shadow_list.size();
                  for (int i = 0; i < shadow_list.size(); i++) begin
                     if (!nan_bits(c.value) && !nan_bits(shadow_list[i]) &&
                         sort_key(shadow_list[i]) > sort_key(c.value)) begin
                        pos = i;
                        break;
                     end
                  end
               end
               shadow_list.insert(pos, c.value);
            end
         end
         CMD_POP: begin
            if (shadow_list.size() == 0) r.status = STATUS_EMPTY;
            else void'(shadow_list.pop_front());
         end
         CMD_CLEAR: shadow_list.delete();
         default: begin
            if (shadow_list.size() == 0) r.status = STATUS_EMPTY;
         end
      endcase
      r.is_empty   = (shadow_list.size() == 0);
      r.head_value = r.is_empty ? 32'd0 : shadow_list[0];
      return r;
   endfunction

   // Pick a float with a bias toward interesting patterns.
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'h0000_0000;
         1: v = 32'h8000_0000;
         2: v = $urandom_range(0, 1) ? 32'h7F80_0000 : 32'hFF80_0000;
         3: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom) | 23'd1};
         4: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h00, 23'($urandom)};
         5: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'd127, 20'd0, 3'($urandom)};
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic cmd_item_type make_cmd(input logic [1:0] op, input logic [31:0] v);
      cmd_item_type c;
      c.command = op;
      c.value   = v;
      return c;
   endfunction

   // Driver: bursts with random gaps; hold valid until the transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0 && !hold_sender) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_cmds[0].command;
            req_tdata  <= pending_cmds[0].value;
            expected_heads.push_back(apply_command(pending_cmds.pop_front()));
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 30);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: long hold-off when asked, otherwise a random stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall > 0) begin
         long_stall <= long_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         case ((cycles / 200) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // Monitor: compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      head_report_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_heads.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            e = expected_heads.pop_front();
            if (rsp_tdata[31:0] !== e.head_value) begin
               $error("head_value expected %h got %h", e.head_value, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[32] !== e.is_empty) begin
               $error("is_empty expected %b got %b", e.is_empty, rsp_tdata[32]);
               errors++;
            end
            if (rsp_tuser !== e.status) begin
               $error("status expected %0d got %0d", e.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || expected_heads.size() > 0 || req_tvalid)
         @(posedge clock);
   endtask

   initial begin
      int fill;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-queue errors, signed zeros, infinities, NaNs, overflow.
      pending_cmds.push_back(make_cmd(CMD_POP, 32'hFFFF_FFFF));
      pending_cmds.push_back(make_cmd(CMD_PEEK, 32'd0));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h0000_0000));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h8000_0000));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h7FC0_0000));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'hFF80_0000));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h7F80_0000));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'hFFFF_FFFF));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h3F80_0000));
      pending_cmds.push_back(make_cmd(CMD_PEEK, 32'd0));
      pending_cmds.push_back(make_cmd(CMD_POP, 32'd0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 32'd0));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h7FC0_0000));
      pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h0000_0001));
      pending_cmds.push_back(make_cmd(CMD_PEEK, 32'd0));
      for (int i = 0; i < CAP + 1; i++)
         pending_cmds.push_back(make_cmd(CMD_PUSH, 32'h4000_0000 - i));
      wait_drained();

      // Back-pressure: stall the receiver while commands keep coming.
      long_stall = 60;
      for (int i = 0; i < 40; i++)
         pending_cmds.push_back(make_cmd(2'($urandom_range(0, 3)), pick_value()));
      wait_drained();
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 32'd0));

      // Random: mostly fill-and-drain sequences, some pure noise.
      fill = 0;
      while (fill < 1800) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 20; i++)
               pending_cmds.push_back(make_cmd(2'($urandom_range(0, 3)), pick_value()));
            fill += 20;
         end else begin
            n = $urandom_range(1, CAP + 2);
            for (int i = 0; i < n; i++)
               pending_cmds.push_back(make_cmd(
                  ($urandom_range(0, 7) == 0) ? CMD_PEEK : CMD_PUSH, pick_value()));
            for (int i = 0; i < n + 1; i++)
               pending_cmds.push_back(make_cmd(
                  ($urandom_range(0, 9) == 0) ? CMD_PUSH : CMD_POP, pick_value()));
            if ($urandom_range(0, 5) == 0)
               pending_cmds.push_back(make_cmd(CMD_CLEAR, $urandom));
            fill += 2 * n + 2;
         end
         if (fill > 900 && fill < 960) begin
            // Wait until all responses are back, then pause the sender.
            wait_drained();
            hold_sender = 1'b1;
            repeat (20) @(posedge clock);
            hold_sender = 1'b0;
         end
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
